/* hdl/fmc_pkg.sv */
// Shared types, codes and defaults for the flow meter calibration block.
`timescale 1ns / 1ps

package fmc_pkg;

  // Default parameter values
  localparam int unsigned PULSE_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned PULSE_IN_W = 32;
  localparam int unsigned VOL_W      = 32;
  localparam int unsigned K_W        = 32;
  localparam int unsigned ZONE_W     = 8;
  localparam int unsigned SECS_W     = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // Item function codes
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_CANCEL = 2'd3;

  // Run controller states
  localparam logic [1:0] RUN_IDLE   = 2'd0;
  localparam logic [1:0] RUN_MOVING = 2'd1;
  localparam logic [1:0] RUN_SETTLE = 2'd2;
  localparam logic [1:0] RUN_FAULT  = 2'd3;

  // Calibration phases
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_RUNNING  = 2'd1;
  localparam logic [1:0] PH_AWAITING = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_NOT_CAL  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_SECONDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLUME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_K       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_K       = 2'd3;

  // Configuration reset values
  localparam logic [SECS_W-1:0] RUN_SECONDS_RST = 16'd60;
  localparam logic [VOL_W-1:0]  MIN_VOLUME_RST  = 32'd6554;
  localparam logic [K_W-1:0]    MIN_K_RST       = 32'd65536;
  localparam logic [K_W-1:0]    MAX_K_RST       = 32'd655360000;

  typedef struct packed {
    logic [1:0]            func;
    logic [ZONE_W-1:0]     zone;
    logic [PULSE_IN_W-1:0] pulse_count;
    logic [1:0]            run_phase;
    logic                  controller_idle;
    logic                  run_granted;
    logic [VOL_W-1:0]      measured_volume;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              request_run;
    logic [ZONE_W-1:0] run_zone;
    logic [SECS_W-1:0] run_duration;
    logic              stop_run;
    logic              raise_fault;
    logic              k_write;
    logic [K_W-1:0]    new_k;
    logic [1:0]        phase_now;
  } out_item_t;

  // Divider handshake
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/fmc_chan_if.sv */
// Valid/ready channel interface carrying one payload item per transfer.
`timescale 1ns / 1ps

interface fmc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/fmc_div.sv */
// Bit-serial restoring divider: (num << 2*FRAC_BITS) / den, saturated to 32 bits.
`timescale 1ns / 1ps

module fmc_div #(
  parameter int unsigned NUM_BITS  = fmc_pkg::PULSE_BITS_DEF,
  parameter int unsigned FRAC_BITS = fmc_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fmc_pkg::div_req_t        req_i,
  input  logic [NUM_BITS-1:0]      num_i,
  input  logic [fmc_pkg::VOL_W-1:0] den_i,
  output fmc_pkg::div_stat_t       stat_o,
  output logic [fmc_pkg::K_W-1:0]  quo_o
);
  import fmc_pkg::*;

  localparam int unsigned Steps = NUM_BITS + 2 * FRAC_BITS;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [NUM_BITS-1:0] num_q;
  logic [VOL_W-1:0]    den_q;
  logic [VOL_W-1:0]    rem_q;
  logic [K_W-1:0]      quo_q;
  logic                sat_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [VOL_W:0]   rem_sh;
  logic [VOL_W+1:0] diff;
  logic             qb;

  // One quotient bit per cycle: shift in next numerator bit, trial subtract
  assign rem_sh = {rem_q, num_q[NUM_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign qb     = ~diff[VOL_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_BITS-2:0], 1'b0};
      rem_q <= qb ? diff[VOL_W-1:0] : rem_sh[VOL_W-1:0];
      // quotient overflows 32 bits once a set top bit is shifted out
      sat_q <= sat_q | quo_q[K_W-1];
      quo_q <= {quo_q[K_W-2:0], qb};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = sat_q ? '1 : quo_q;

endmodule

/* hdl/flow_meter_calibration.sv */
// Flow meter calibration controller top level.
//
// Input channel in_i carries one command item (start, tick, finish, cancel);
// output channel out_o returns exactly one result item per command, in order.
// Both are valid/ready; a transfer happens when valid and ready are high.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// while no command is in flight; indexes follow the register list.
//
// Start, tick, cancel and finish with a rejected volume: the result is registered
// in the holding register and then in the output register once that is free.
// Finish that computes K: the result first waits until the bit-serial divider,
// producing one quotient bit per cycle, is done, then takes the same path.
// A command is taken only while no other command is being processed; a
// result that waits on a stalled receiver sits in the output register while
// the next command is accepted and worked on. That command's result then
// waits in an internal holding register, and input stays blocked.
// Reset (rst_ni low, asynchronous) returns the phase to idle, clears the
// baseline and tally, restores the configuration defaults and drops out_o.valid.
`timescale 1ns / 1ps

module flow_meter_calibration #(
  parameter int unsigned PULSE_BITS = fmc_pkg::PULSE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = fmc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fmc_chan_if.sink                       in_i,
  fmc_chan_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [fmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fmc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  // Configuration registers
  logic [SECS_W-1:0] run_seconds_q;
  logic [VOL_W-1:0]  min_volume_q;
  logic [K_W-1:0]    min_k_q;
  logic [K_W-1:0]    max_k_q;

  // Calibration state
  logic [1:0]            phase_q, phase_d;
  logic [PULSE_BITS-1:0] baseline_q, baseline_d;
  logic [PULSE_BITS-1:0] tally_q, tally_d;

  logic [1:0] state_q;
  out_item_t  res_q, res_d;
  out_item_t  out_q;
  logic       out_valid_q;
  logic       safe_q, safe_d;
  logic       go_div;

  in_item_t              item;
  logic                  in_fire;
  logic                  out_free;
  logic [PULSE_BITS-1:0] pulses;
  logic [PULSE_BITS-1:0] delta;
  logic                  owns;

  div_req_t   div_req;
  div_stat_t  div_stat;
  logic [K_W-1:0] div_quo;

  assign item     = in_i.data;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign pulses   = PULSE_BITS'(item.pulse_count);
  assign delta    = pulses - baseline_q;
  assign owns     = (phase_q == PH_RUNNING);

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_seconds_q <= RUN_SECONDS_RST;
      min_volume_q  <= MIN_VOLUME_RST;
      min_k_q       <= MIN_K_RST;
      max_k_q       <= MAX_K_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RUN_SECONDS: run_seconds_q <= cfg_data_i[SECS_W-1:0];
        CFG_MIN_VOLUME:  min_volume_q  <= cfg_data_i[VOL_W-1:0];
        CFG_MIN_K:       min_k_q       <= cfg_data_i[K_W-1:0];
        CFG_MAX_K:       max_k_q       <= cfg_data_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode: next state and immediate result fields
  always_comb begin
    res_d      = '0;
    phase_d    = phase_q;
    baseline_d = baseline_q;
    tally_d    = tally_q;
    safe_d     = 1'b0;
    go_div     = 1'b0;
    case (item.func)
      FUNC_START: begin
        if (phase_q != PH_IDLE || !item.controller_idle || !item.run_granted) begin
          res_d.status = ST_REFUSED;
        end else begin
          res_d.request_run  = 1'b1;
          res_d.run_zone     = item.zone;
          res_d.run_duration = run_seconds_q;
          baseline_d         = pulses;
          tally_d            = '0;
          phase_d            = PH_RUNNING;
        end
      end
      FUNC_TICK: begin
        if (owns) begin
          tally_d = delta;
          if (item.run_phase == RUN_FAULT) begin
            phase_d = PH_IDLE;
            tally_d = '0;
          end else if (item.run_phase == RUN_SETTLE || item.run_phase == RUN_IDLE) begin
            phase_d = PH_AWAITING;
          end
        end
      end
      FUNC_FINISH: begin
        if (phase_q == PH_IDLE) begin
          res_d.status = ST_NOT_CAL;
        end else begin
          if (owns) begin
            tally_d        = delta;
            res_d.stop_run = 1'b1;
          end
          phase_d = PH_IDLE;
          safe_d  = owns || item.controller_idle;
          if (item.measured_volume < min_volume_q) begin
            res_d.status      = ST_REJECTED;
            res_d.raise_fault = safe_d;
          end else begin
            go_div = 1'b1;
          end
        end
      end
      default: begin
        res_d.stop_run = owns;
        phase_d        = PH_IDLE;
        tally_d        = '0;
      end
    endcase
    res_d.phase_now = phase_d;
  end

  assign div_req.start = in_fire && go_div;

  fmc_div #(
    .NUM_BITS  (PULSE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (tally_d),
    .den_i  (item.measured_volume),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // Sequencer and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      baseline_q  <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            phase_q    <= phase_d;
            baseline_q <= baseline_d;
            tally_q    <= tally_d;
            state_q    <= go_div ? S_DIV : S_EMIT;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result holding and output registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q  <= res_d;
      safe_q <= safe_d;
    end else if (state_q == S_DIV && div_stat.done) begin
      res_q.new_k <= div_quo;
      if (div_quo < min_k_q || div_quo > max_k_q) begin
        res_q.status      <= ST_REJECTED;
        res_q.raise_fault <= safe_q;
      end else begin
        res_q.k_write <= 1'b1;
      end
    end
    if (state_q == S_EMIT && out_free) begin
      out_q <= res_q;
    end
  end

endmodule

/* tb/sv/fmc_calibration_checker.sv */
// Calibration checker: predicts each result from accepted commands and compares.
`timescale 1ns / 1ps

module fmc_calibration_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  logic                           cmd_ready_i,
  input  fmc_pkg::in_item_t              cmd_data_i,
  input  logic                           res_valid_i,
  input  logic                           res_ready_i,
  input  fmc_pkg::out_item_t             res_data_i,
  input  logic                           cfg_we_i,
  input  logic [fmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);
  import fmc_pkg::*;

  localparam int unsigned FRAC_BITS = FRAC_BITS_DEF;

  // Shadow copy of the configuration registers
  logic [SECS_W-1:0] run_secs;
  logic [VOL_W-1:0]  vol_floor;
  logic [K_W-1:0]    k_floor;
  logic [K_W-1:0]    k_ceiling;

  // Shadow copy of the calibration state
  logic [1:0]            cal_phase;
  logic [PULSE_IN_W-1:0] base_count;
  logic [PULSE_IN_W-1:0] pulse_tally;

  out_item_t expected_results[$];

  initial errors_o = 0;

  // K = tally / volume in Q16.16, saturating at all ones
  function automatic logic [K_W-1:0] k_factor(input logic [PULSE_IN_W-1:0] pulses,
                                              input logic [VOL_W-1:0] vol);
    logic [63:0] quot;
    if (vol == '0) return '1;
    quot = ({32'h0, pulses} << (2 * FRAC_BITS)) / {32'h0, vol};
    if (quot[63:K_W] != '0) return '1;
    return quot[K_W-1:0];
  endfunction

  // Apply one command to the shadow state and build its result
  task automatic advance_calibration(input in_item_t cmd, output out_item_t res);
    logic           owns;
    logic           safe;
    logic [K_W-1:0] k;
    res = '0;
    case (cmd.func)
      FUNC_START: begin
        if (cal_phase != PH_IDLE || !cmd.controller_idle || !cmd.run_granted) begin
          res.status = ST_REFUSED;
        end else begin
          res.request_run  = 1'b1;
          res.run_zone     = cmd.zone;
          res.run_duration = run_secs;
          base_count       = cmd.pulse_count;
          pulse_tally      = '0;
          cal_phase        = PH_RUNNING;
        end
      end
      FUNC_TICK: begin
        if (cal_phase == PH_RUNNING) begin
          pulse_tally = cmd.pulse_count - base_count;
          if (cmd.run_phase == RUN_FAULT) begin
            cal_phase   = PH_IDLE;
            pulse_tally = '0;
          end else if (cmd.run_phase == RUN_SETTLE || cmd.run_phase == RUN_IDLE) begin
            cal_phase = PH_AWAITING;
          end
        end
      end
      FUNC_FINISH: begin
        if (cal_phase == PH_IDLE) begin
          res.status = ST_NOT_CAL;
        end else begin
          owns = (cal_phase == PH_RUNNING);
          if (owns) begin
            pulse_tally  = cmd.pulse_count - base_count;
            res.stop_run = 1'b1;
          end
          cal_phase = PH_IDLE;
          safe      = owns || cmd.controller_idle;
          if (cmd.measured_volume < vol_floor) begin
            res.status      = ST_REJECTED;
            res.raise_fault = safe;
          end else begin
            k         = k_factor(pulse_tally, cmd.measured_volume);
            res.new_k = k;
            if (k < k_floor || k > k_ceiling) begin
              res.status      = ST_REJECTED;
              res.raise_fault = safe;
            end else begin
              res.k_write = 1'b1;
            end
          end
        end
      end
      default: begin
        // cancel
        res.stop_run = (cal_phase == PH_RUNNING);
        cal_phase    = PH_IDLE;
        pulse_tally  = '0;
      end
    endcase
    res.phase_now = cal_phase;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors_o = errors_o + 1;
    end
  endtask

  // Track config writes, check result transfers, predict command transfers
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    out_item_t res;
    if (!rst_ni) begin
      run_secs    = RUN_SECONDS_RST;
      vol_floor   = MIN_VOLUME_RST;
      k_floor     = MIN_K_RST;
      k_ceiling   = MAX_K_RST;
      cal_phase   = PH_IDLE;
      base_count  = '0;
      pulse_tally = '0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RUN_SECONDS: run_secs  = cfg_data_i[SECS_W-1:0];
          CFG_MIN_VOLUME:  vol_floor = cfg_data_i[VOL_W-1:0];
          CFG_MIN_K:       k_floor   = cfg_data_i[K_W-1:0];
          CFG_MAX_K:       k_ceiling = cfg_data_i[K_W-1:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, res_data_i);
          errors_o = errors_o + 1;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(res_data_i.status));
          compare_field("request_run", 32'(want.request_run), 32'(res_data_i.request_run));
          compare_field("run_zone", 32'(want.run_zone), 32'(res_data_i.run_zone));
          compare_field("run_duration", 32'(want.run_duration),
                        32'(res_data_i.run_duration));
          compare_field("stop_run", 32'(want.stop_run), 32'(res_data_i.stop_run));
          compare_field("raise_fault", 32'(want.raise_fault), 32'(res_data_i.raise_fault));
          compare_field("k_write", 32'(want.k_write), 32'(res_data_i.k_write));
          compare_field("new_k", want.new_k, res_data_i.new_k);
          compare_field("phase_now", 32'(want.phase_now), 32'(res_data_i.phase_now));
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        advance_calibration(cmd_data_i, res);
        expected_results.push_back(res);
      end
    end
    pending_o <= expected_results.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
  import fmc_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int items_sent = 0;
  int stall_cycles = 0;
  bit quiet_mode = 1'b0;

  fmc_chan_if #(.T(in_item_t))  cmd_ch ();
  fmc_chan_if #(.T(out_item_t)) res_ch ();

  flow_meter_calibration dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  fmc_calibration_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_ch.valid),
    .cmd_ready_i (cmd_ch.ready),
    .cmd_data_i  (cmd_ch.data),
    .res_valid_i (res_ch.valid),
    .res_ready_i (res_ch.ready),
    .res_data_i  (res_ch.data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result back-pressure
  initial begin
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin : backpressure
      int gap;
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One command transfer, after a random idle gap
  task automatic send_cmd(input logic [1:0] func, input logic [ZONE_W-1:0] zone,
                          input logic [PULSE_IN_W-1:0] pulses, input logic [1:0] rphase,
                          input logic idle, input logic grant,
                          input logic [VOL_W-1:0] vol);
    in_item_t cmd;
    int gap;
    cmd.func            = func;
    cmd.zone            = zone;
    cmd.pulse_count     = pulses;
    cmd.run_phase       = rphase;
    cmd.controller_idle = idle;
    cmd.run_granted     = grant;
    cmd.measured_volume = vol;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= cmd;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [SECS_W-1:0] secs, input logic [VOL_W-1:0] minv,
                                input logic [K_W-1:0] mink, input logic [K_W-1:0] maxk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RUN_SECONDS;
    cfg_data <= {16'h0, secs};
    @(posedge clk_i);
    cfg_idx  <= CFG_MIN_VOLUME;
    cfg_data <= minv;
    @(posedge clk_i);
    cfg_idx  <= CFG_MIN_K;
    cfg_data <= mink;
    @(posedge clk_i);
    cfg_idx  <= CFG_MAX_K;
    cfg_data <= maxk;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Start, a few ticks, then finish, cancel or nothing
  task automatic run_session();
    logic [PULSE_IN_W-1:0] pulses;
    logic [VOL_W-1:0]      vol;
    logic [1:0]            rph;
    int                    r;
    pulses = $urandom;
    send_cmd(FUNC_START, ZONE_W'($urandom), pulses, 2'($urandom),
             $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, $urandom);
    repeat ($urandom_range(0, 4)) begin
      pulses = pulses + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20000));
      r = $urandom_range(0, 99);
      rph = (r < 70) ? RUN_MOVING : (r < 80) ? RUN_SETTLE : (r < 90) ? RUN_IDLE : RUN_FAULT;
      send_cmd(FUNC_TICK, ZONE_W'($urandom), pulses, rph, 1'($urandom), 1'($urandom),
               $urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      pulses = pulses + $urandom_range(0, 20000);
      r = $urandom_range(0, 99);
      if (r < 55)      vol = $urandom_range(32'h0000_4000, 32'h0040_0000);
      else if (r < 75) vol = $urandom;
      else             vol = $urandom_range(0, 32'h0000_FFFF);
      send_cmd(FUNC_FINISH, ZONE_W'($urandom), pulses, 2'($urandom), 1'($urandom),
               1'($urandom), vol);
    end else if (r < 90) begin
      send_cmd(FUNC_CANCEL, ZONE_W'($urandom), $urandom, 2'($urandom), 1'($urandom),
               1'($urandom), $urandom);
    end
  endtask

  // Mostly well-formed sessions, some raw noise commands
  task automatic random_traffic(input int count, input bit calm);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      quiet_mode = calm || ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 99) < 15)
        send_cmd(2'($urandom), ZONE_W'($urandom), $urandom, 2'($urandom), 1'($urandom),
                 1'($urandom), $urandom);
      else
        run_session();
    end
  endtask

  initial begin
    logic [K_W-1:0] mink;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    rst_ni       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset configuration: commands outside a calibration
    send_cmd(FUNC_FINISH, 8'h00, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0001_0000);
    send_cmd(FUNC_TICK, 8'hFF, 32'hFFFF_FFFF, RUN_FAULT, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_cmd(FUNC_CANCEL, 8'h00, 32'h0, RUN_MOVING, 1'b0, 1'b0, 32'h0);
    // start refused: controller busy, then run not granted
    send_cmd(FUNC_START, 8'h11, 32'h0, RUN_IDLE, 1'b0, 1'b1, 32'h0);
    send_cmd(FUNC_START, 8'h22, 32'h0, RUN_IDLE, 1'b1, 1'b0, 32'h0);
    // accepted start with baseline near wrap, refused restart, wrapping tally, K written
    send_cmd(FUNC_START, 8'hFF, 32'hFFFF_FFF0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_START, 8'h33, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_TICK, 8'h00, 32'h0000_0100, RUN_MOVING, 1'b0, 1'b0, 32'h0);
    send_cmd(FUNC_FINISH, 8'h00, 32'h0000_0200, RUN_MOVING, 1'b0, 1'b0, 32'h0001_0000);
    // settle freezes the tally; finish not owning the run, busy controller, low volume
    send_cmd(FUNC_START, 8'h00, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_TICK, 8'h00, 32'd5000, RUN_SETTLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_TICK, 8'h00, 32'd9999, RUN_MOVING, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_FINISH, 8'h00, 32'd7777, RUN_MOVING, 1'b0, 1'b1, 32'd6553);
    // idle run state, largest tally, K saturates above the range
    send_cmd(FUNC_START, 8'h01, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_TICK, 8'h00, 32'hFFFF_FFFF, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_FINISH, 8'h00, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'd6554);
    // run fault voids the calibration
    send_cmd(FUNC_START, 8'h02, 32'h1234_5678, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_TICK, 8'h00, 32'h1234_9999, RUN_FAULT, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_FINISH, 8'h00, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0001_0000);
    // owned finish with zero tally: K below the range
    send_cmd(FUNC_START, 8'h03, 32'h8000_0000, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_FINISH, 8'h00, 32'h8000_0000, RUN_MOVING, 1'b0, 1'b0, 32'hFFFF_FFFF);
    // cancel while running and while awaiting
    send_cmd(FUNC_START, 8'h04, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_CANCEL, 8'h00, 32'h0, RUN_MOVING, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_START, 8'h05, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_TICK, 8'h00, 32'h10, RUN_SETTLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_CANCEL, 8'h00, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    settle();

    // Widest range: zero volume saturates K, zero K sits on the lower bound
    apply_settings(16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_cmd(FUNC_START, 8'h06, 32'h0, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_FINISH, 8'h00, 32'd100, RUN_MOVING, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_START, 8'h07, 32'h55AA_55AA, RUN_IDLE, 1'b1, 1'b1, 32'h0);
    send_cmd(FUNC_FINISH, 8'h00, 32'h55AA_55AA, RUN_MOVING, 1'b1, 1'b1, 32'h1);
    random_traffic(130, 1'b0);
    settle();

    // Empty range, largest volume floor
    apply_settings(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    random_traffic(60, 1'b0);
    settle();

    // Random moderate settings
    repeat (2) begin
      mink = $urandom_range(0, 32'h0010_0000);
      apply_settings(SECS_W'($urandom_range(1, 65535)), $urandom_range(1, 32'h0004_0000),
                     mink, mink + $urandom_range(32'h0010_0000, 32'h4000_0000));
      random_traffic(150, 1'b0);
      settle();
    end

    // Back to the reset values, no idling on either side
    apply_settings(RUN_SECONDS_RST, MIN_VOLUME_RST, MIN_K_RST, MAX_K_RST);
    random_traffic(150, 1'b1);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* flow_meter_calibration.f */
hdl/fmc_pkg.sv
hdl/fmc_chan_if.sv
hdl/fmc_div.sv
hdl/flow_meter_calibration.sv
tb/sv/fmc_calibration_checker.sv
tb/sv/tb_top.sv
